// ===== design/ttp_pkg.sv =====
`timescale 1ns / 1ps

package ttp_pkg;

    // widths and limits
    localparam int MAX_CHARS_DEF = 64;
    localparam int FIELD_W       = 31;
    localparam int FRAC_W        = 30;
    localparam int FDIG_W        = 4;
    localparam int COUNT_W       = 7;
    localparam int HOUR_W        = 22;
    localparam int NS_W          = 64;

    localparam logic [HOUR_W-1:0]  HOUR_LIMIT_RESET = 22'd2562047;
    localparam logic [FIELD_W+3:0] FIELD_MAX        = 35'h07FFFFFFF;
    localparam logic [FDIG_W-1:0]  FRAC_DIGITS      = 4'd9;
    localparam logic [FIELD_W-1:0] HOUR_CLOCK       = 31'd12;
    localparam logic [FRAC_W-1:0]  NS_PER_SEC       = 30'd1000000000;

    // character codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'd32;

    typedef enum logic [3:0] {
        PH_START,
        PH_SIGNED,
        PH_HOUR,
        PH_MIN_FIRST,
        PH_MIN,
        PH_SEC_FIRST,
        PH_SEC,
        PH_FRAC,
        PH_MER,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        MER_NONE,
        MER_AM,
        MER_PM
    } t_mer;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic                   ok;
        logic signed [NS_W-1:0] nanoseconds;
        logic [COUNT_W-1:0]     consumed;
    } t_out_item;

    // parse state after the last character of a string
    typedef struct packed {
        logic               err;
        logic               negative;
        logic [FIELD_W-1:0] first;
        logic [FIELD_W-1:0] second;
        logic [FIELD_W-1:0] third;
        logic               third_present;
        logic [FRAC_W-1:0]  frac_value;
        logic [FDIG_W-1:0]  frac_digits;
        t_mer               meridiem;
        logic [COUNT_W-1:0] count;
    } t_snap;

    // scale factor that brings a fraction with this many digits to nine digits
    function automatic logic [FRAC_W-1:0] frac_scale(input logic [FDIG_W-1:0] digits);
        case (digits)
            4'd0:    frac_scale = 30'd1000000000;
            4'd1:    frac_scale = 30'd100000000;
            4'd2:    frac_scale = 30'd10000000;
            4'd3:    frac_scale = 30'd1000000;
            4'd4:    frac_scale = 30'd100000;
            4'd5:    frac_scale = 30'd10000;
            4'd6:    frac_scale = 30'd1000;
            4'd7:    frac_scale = 30'd100;
            4'd8:    frac_scale = 30'd10;
            default: frac_scale = 30'd1;
        endcase
    endfunction

endpackage

// ===== design/ttp_scanner.sv =====
`timescale 1ns / 1ps

module ttp_scanner #(
    parameter int MAX_CHARS = ttp_pkg::MAX_CHARS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  ttp_pkg::t_in_item i_item,
    output ttp_pkg::t_snap   o_snap
);
    import ttp_pkg::*;

    localparam int RCV_W = $clog2(MAX_CHARS + 2);

    t_phase             r_phase, n_phase;
    logic               r_negative, n_negative;
    logic [FIELD_W-1:0] r_first, n_first;
    logic [FIELD_W-1:0] r_second, n_second;
    logic [FIELD_W-1:0] r_third, n_third;
    logic               r_third_present, n_third_present;
    logic [FRAC_W-1:0]  r_frac_value, n_frac_value;
    logic [FDIG_W-1:0]  r_frac_digits, n_frac_digits;
    t_mer               r_mer, n_mer;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [RCV_W-1:0]   r_received, n_received;
    logic               r_failed, n_failed;

    logic [7:0]         c;
    logic [7:0]         up;
    logic [3:0]         digit;
    logic               is_dig, is_sign, is_sep, is_colon, is_am, is_pm;
    logic               too_long, run;
    logic [FIELD_W-1:0] field_sel;
    logic [FIELD_W+3:0] push_val;
    logic               push_ovf;
    logic [FRAC_W+3:0]  frac_acc;
    logic [COUNT_W-1:0] cnt_inc, cnt_inc2;

    // character classes
    assign c        = i_item.char_code;
    assign digit    = c[3:0];
    assign is_dig   = c inside {[CH_0:CH_9]};
    assign up       = (c inside {[CH_LO_A:CH_LO_Z]}) ? c - CASE_GAP : c;
    assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
    assign is_sep   = (c == CH_DOT) || (c == CH_COMMA);
    assign is_colon = (c == CH_COLON);
    assign is_am    = (up == CH_A);
    assign is_pm    = (up == CH_P);

    // length limit
    assign n_received = (r_received <= RCV_W'(MAX_CHARS)) ? r_received + 1'b1 : r_received;
    assign too_long   = (n_received > RCV_W'(MAX_CHARS));
    assign run        = !r_failed && !too_long;

    // digit push into the field of the current phase, times ten plus digit
    always_comb begin
        case (r_phase)
            PH_MIN_FIRST, PH_MIN: field_sel = r_second;
            PH_SEC_FIRST, PH_SEC: field_sel = r_third;
            default:              field_sel = r_first;
        endcase
    end
    assign push_val = ({4'd0, field_sel} << 3) + ({4'd0, field_sel} << 1) + (FIELD_W+4)'(digit);
    assign push_ovf = (push_val > FIELD_MAX);
    assign frac_acc = ({4'd0, r_frac_value} << 3) + ({4'd0, r_frac_value} << 1)
                      + (FRAC_W+4)'(digit);
    assign cnt_inc  = r_count + 7'd1;
    assign cnt_inc2 = r_count + 7'd2;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (run) begin
            case (r_phase)
                PH_START, PH_SIGNED, PH_HOUR: begin
                    if (is_sign && r_phase == PH_START) begin
                        n_phase = PH_SIGNED;
                    end else if (is_dig) begin
                        n_phase = PH_HOUR;
                    end else if (is_colon) begin
                        n_phase = PH_MIN_FIRST;
                    end
                end
                PH_MIN_FIRST: begin
                    if (is_dig) begin
                        n_phase = PH_MIN;
                    end
                end
                PH_MIN: begin
                    if (is_dig) begin
                        n_phase = PH_MIN;
                    end else if (is_colon) begin
                        n_phase = PH_SEC_FIRST;
                    end else if (is_sep) begin
                        n_phase = PH_FRAC;
                    end else if (is_am || is_pm) begin
                        n_phase = PH_MER;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_SEC_FIRST: begin
                    if (is_dig) begin
                        n_phase = PH_SEC;
                    end
                end
                PH_SEC: begin
                    if (is_dig) begin
                        n_phase = PH_SEC;
                    end else if (is_sep) begin
                        n_phase = PH_FRAC;
                    end else if (is_am || is_pm) begin
                        n_phase = PH_MER;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_FRAC: begin
                    if (is_dig) begin
                        n_phase = PH_FRAC;
                    end else if (is_am || is_pm) begin
                        n_phase = PH_MER;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_MER:  n_phase = PH_DONE;
                default: n_phase = r_phase;
            endcase
        end
    end

    // field, count and flag updates
    always_comb begin
        n_negative      = r_negative;
        n_first         = r_first;
        n_second        = r_second;
        n_third         = r_third;
        n_third_present = r_third_present;
        n_frac_value    = r_frac_value;
        n_frac_digits   = r_frac_digits;
        n_mer           = r_mer;
        n_count         = r_count;
        n_failed        = r_failed | too_long;
        if (run) begin
            case (r_phase)
                PH_START, PH_SIGNED, PH_HOUR: begin
                    if (is_sign && r_phase == PH_START) begin
                        n_negative = (c == CH_MINUS);
                        n_count    = cnt_inc;
                    end else if (is_dig) begin
                        if (push_ovf) begin
                            n_failed = 1'b1;
                        end else begin
                            n_first = push_val[FIELD_W-1:0];
                            n_count = cnt_inc;
                        end
                    end else if (is_colon) begin
                        n_count = cnt_inc;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_MIN_FIRST, PH_MIN: begin
                    if (is_dig) begin
                        if (push_ovf) begin
                            n_failed = 1'b1;
                        end else begin
                            n_second = push_val[FIELD_W-1:0];
                            n_count  = cnt_inc;
                        end
                    end else if (r_phase == PH_MIN_FIRST) begin
                        n_failed = 1'b1;
                    end else if (is_colon || is_sep) begin
                        n_count = cnt_inc;
                    end else if (is_am) begin
                        n_mer = MER_AM;
                    end else if (is_pm) begin
                        n_mer = MER_PM;
                    end
                end
                PH_SEC_FIRST, PH_SEC: begin
                    if (is_dig) begin
                        n_third_present = 1'b1;
                        if (push_ovf) begin
                            n_failed = 1'b1;
                        end else begin
                            n_third = push_val[FIELD_W-1:0];
                            n_count = cnt_inc;
                        end
                    end else if (r_phase == PH_SEC_FIRST) begin
                        n_failed = 1'b1;
                    end else if (is_sep) begin
                        n_count = cnt_inc;
                    end else if (is_am) begin
                        n_mer = MER_AM;
                    end else if (is_pm) begin
                        n_mer = MER_PM;
                    end
                end
                PH_FRAC: begin
                    if (is_dig) begin
                        n_count = cnt_inc;
                        // digits past the ninth are consumed but dropped
                        if (r_frac_digits < FRAC_DIGITS) begin
                            n_frac_value  = frac_acc[FRAC_W-1:0];
                            n_frac_digits = r_frac_digits + 1'b1;
                        end
                    end else if (is_am) begin
                        n_mer = MER_AM;
                    end else if (is_pm) begin
                        n_mer = MER_PM;
                    end
                end
                PH_MER: begin
                    if (up == CH_M) begin
                        n_count = cnt_inc2;
                    end else begin
                        n_mer = MER_NONE;
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // state after this character, as seen by the finishing pipeline
    always_comb begin
        o_snap.err = n_failed || (n_phase inside {PH_START, PH_SIGNED, PH_HOUR,
                                                  PH_MIN_FIRST, PH_SEC_FIRST});
        o_snap.negative      = n_negative;
        o_snap.first         = n_first;
        o_snap.second        = n_second;
        o_snap.third         = n_third;
        o_snap.third_present = n_third_present;
        o_snap.frac_value    = n_frac_value;
        o_snap.frac_digits   = n_frac_digits;
        // a lone A or P without M is no meridiem
        o_snap.meridiem      = (n_phase == PH_MER) ? MER_NONE : n_mer;
        o_snap.count         = n_count;
    end

    // parse state, cleared after the last character of each string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_item.is_last)) begin
            r_phase         <= PH_START;
            r_negative      <= 1'b0;
            r_first         <= '0;
            r_second        <= '0;
            r_third         <= '0;
            r_third_present <= 1'b0;
            r_frac_value    <= '0;
            r_frac_digits   <= '0;
            r_mer           <= MER_NONE;
            r_count         <= '0;
            r_received      <= '0;
            r_failed        <= 1'b0;
        end else if (i_take) begin
            r_phase         <= n_phase;
            r_negative      <= n_negative;
            r_first         <= n_first;
            r_second        <= n_second;
            r_third         <= n_third;
            r_third_present <= n_third_present;
            r_frac_value    <= n_frac_value;
            r_frac_digits   <= n_frac_digits;
            r_mer           <= n_mer;
            r_count         <= n_count;
            r_received      <= n_received;
            r_failed        <= n_failed;
        end
    end

endmodule

// ===== design/time_text_parser.sv =====
`timescale 1ns / 1ps

// channel  | valid       | ready       | payload
// ---------+-------------+-------------+---------------------------------------
// input    | i_in_valid  | o_in_ready  | i_in_data  (char_code, is_last)
// output   | o_out_valid | i_out_ready | o_out_data (ok, nanoseconds, consumed)
// config   | i_cfg_we    | -           | i_cfg_data (hour limit)
//
// one character is taken per cycle while input ready is high; non-final characters
// update the parse state only; the final character launches a result through a
// 5-stage finishing pipeline sized by the split seconds-to-nanoseconds multiply
// reset is synchronous and active low; it clears the parse state and reloads the hour limit
// a stalled output backs up the pipeline stage by stage; input ready drops only
// when the first finishing stage is full and cannot move

module time_text_parser #(
    parameter int MAX_CHARS = ttp_pkg::MAX_CHARS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  ttp_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output ttp_pkg::t_out_item          o_out_data,
    input  logic                        i_cfg_we,
    input  logic [ttp_pkg::HOUR_W-1:0]  i_cfg_data
);
    import ttp_pkg::*;

    localparam int SECS_W = 38;
    localparam int HALF_W = SECS_W / 2;
    localparam int PROD_W = HALF_W + FRAC_W;
    localparam int SUM_W  = PROD_W + HALF_W + 1;
    localparam int MAG_W  = NS_W - 1;
    localparam logic [SUM_W-1:0] TOTAL_MAX = {{(SUM_W-MAG_W){1'b0}}, {MAG_W{1'b1}}};

    logic [HOUR_W-1:0]  r_hour_limit;

    t_snap              snap;
    logic               in_xfer;
    logic               out_free, p1_free, p2_free, p3_free, p4_free, p5_free;

    logic               r_p1_valid;
    t_snap              r_p1;

    logic               r_p2_valid;
    logic               r_p2_err, r_p2_neg, r_p2_hh;
    logic [HOUR_W-1:0]  r_p2_h, r_p2_first;
    logic [FIELD_W-1:0] r_p2_second, r_p2_third;
    logic [FRAC_W-1:0]  r_p2_frac;
    logic [COUNT_W-1:0] r_p2_count;

    logic               r_p3_valid;
    logic               r_p3_err, r_p3_neg;
    logic [SECS_W-1:0]  r_p3_secs;
    logic [FRAC_W-1:0]  r_p3_frac;
    logic [COUNT_W-1:0] r_p3_count;

    logic               r_p4_valid;
    logic               r_p4_err, r_p4_neg;
    logic [PROD_W-1:0]  r_p4_lo, r_p4_hi;
    logic [FRAC_W-1:0]  r_p4_frac;
    logic [COUNT_W-1:0] r_p4_count;

    logic               r_p5_valid;
    logic               r_p5_err, r_p5_neg;
    logic [MAG_W-1:0]   r_p5_mag;
    logic [COUNT_W-1:0] r_p5_count;

    logic               r_out_valid;
    t_out_item          r_out;

    logic               over_hour, mer_set, mode_hh, mer_err;
    logic [HOUR_W-1:0]  h_base, h_adj;
    logic [2*FRAC_W-1:0] frac_full;
    logic [SECS_W-1:0]  secs;
    logic [SUM_W-1:0]   total;

    // stage flow: a stage may load when empty or when its content moves on
    assign out_free   = !r_out_valid || i_out_ready;
    assign p5_free    = !r_p5_valid || out_free;
    assign p4_free    = !r_p4_valid || p5_free;
    assign p3_free    = !r_p3_valid || p4_free;
    assign p2_free    = !r_p2_valid || p3_free;
    assign p1_free    = !r_p1_valid || p2_free;
    assign o_in_ready = p1_free;
    assign in_xfer    = i_in_valid && o_in_ready;

    // character scanner
    ttp_scanner #(
        .MAX_CHARS (MAX_CHARS)
    ) u_scanner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (in_xfer),
        .i_item  (i_in_data),
        .o_snap  (snap)
    );

    // hour limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour_limit <= HOUR_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_hour_limit <= i_cfg_data;
        end
    end

    // stage 1: snapshot of the parse state at the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (p1_free) begin
            r_p1_valid <= in_xfer && i_in_data.is_last;
        end
    end
    always_ff @(posedge i_clk) begin
        if (p1_free && in_xfer && i_in_data.is_last) begin
            r_p1 <= snap;
        end
    end

    // stage 2: hour limit, meridiem rules, mode and fraction scaling
    assign over_hour = (r_p1.first > {{(FIELD_W-HOUR_W){1'b0}}, r_hour_limit});
    assign mer_set   = (r_p1.meridiem != MER_NONE);
    assign mode_hh   = r_p1.third_present || (r_p1.frac_value == '0);
    assign mer_err   = mer_set && (!mode_hh || (r_p1.first > HOUR_CLOCK));
    assign h_base    = (r_p1.first == HOUR_CLOCK) ? '0 : r_p1.first[HOUR_W-1:0];
    assign h_adj     = !mer_set ? r_p1.first[HOUR_W-1:0] :
                       (r_p1.meridiem == MER_PM) ? h_base + HOUR_W'(HOUR_CLOCK) : h_base;
    assign frac_full = (2*FRAC_W)'(r_p1.frac_value) * (2*FRAC_W)'(frac_scale(r_p1.frac_digits));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (p2_free) begin
            r_p2_valid <= r_p1_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (p2_free && r_p1_valid) begin
            r_p2_err    <= r_p1.err || over_hour || mer_err;
            r_p2_neg    <= r_p1.negative;
            r_p2_hh     <= mode_hh;
            r_p2_h      <= h_adj;
            r_p2_first  <= r_p1.first[HOUR_W-1:0];
            r_p2_second <= r_p1.second;
            r_p2_third  <= r_p1.third_present ? r_p1.third : '0;
            r_p2_frac   <= frac_full[FRAC_W-1:0];
            r_p2_count  <= r_p1.count;
        end
    end

    // stage 3: whole seconds
    assign secs = r_p2_hh ?
                  SECS_W'(r_p2_h) * SECS_W'(3600) + SECS_W'(r_p2_second) * SECS_W'(60)
                  + SECS_W'(r_p2_third) :
                  SECS_W'(r_p2_first) * SECS_W'(60) + SECS_W'(r_p2_second);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_valid <= 1'b0;
        end else if (p3_free) begin
            r_p3_valid <= r_p2_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (p3_free && r_p2_valid) begin
            r_p3_err   <= r_p2_err;
            r_p3_neg   <= r_p2_neg;
            r_p3_secs  <= secs;
            r_p3_frac  <= r_p2_frac;
            r_p3_count <= r_p2_count;
        end
    end

    // stage 4: seconds to nanoseconds, in two half-width products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_valid <= 1'b0;
        end else if (p4_free) begin
            r_p4_valid <= r_p3_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (p4_free && r_p3_valid) begin
            r_p4_err   <= r_p3_err;
            r_p4_neg   <= r_p3_neg;
            r_p4_lo    <= PROD_W'(r_p3_secs[HALF_W-1:0]) * PROD_W'(NS_PER_SEC);
            r_p4_hi    <= PROD_W'(r_p3_secs[SECS_W-1:HALF_W]) * PROD_W'(NS_PER_SEC);
            r_p4_frac  <= r_p3_frac;
            r_p4_count <= r_p3_count;
        end
    end

    // stage 5: total and overflow check
    assign total = {1'b0, r_p4_hi, {HALF_W{1'b0}}} + SUM_W'(r_p4_lo) + SUM_W'(r_p4_frac);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_valid <= 1'b0;
        end else if (p5_free) begin
            r_p5_valid <= r_p4_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (p5_free && r_p4_valid) begin
            r_p5_err   <= r_p4_err || (total > TOTAL_MAX);
            r_p5_neg   <= r_p4_neg;
            r_p5_mag   <= total[MAG_W-1:0];
            r_p5_count <= r_p4_count;
        end
    end

    // output register: sign applied, zeroed on error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_p5_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (out_free && r_p5_valid) begin
            r_out.ok          <= !r_p5_err;
            r_out.nanoseconds <= r_p5_err ? '0 :
                                 r_p5_neg ? NS_W'(0) - {1'b0, r_p5_mag} : {1'b0, r_p5_mag};
            r_out.consumed    <= r_p5_err ? '0 : r_p5_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== design/ttp_checker.sv =====
`timescale 1ns / 1ps

module ttp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ttp_pkg::t_out_item  o_out_data
);
    import ttp_pkg::*;

    // a failed parse reports nothing but the flag
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.ok |->
            (o_out_data.nanoseconds == '0) && (o_out_data.consumed == '0))
        else $error("error result carries a value or a count");

    // a good parse used at least a colon and one minute digit, never past the limit
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.ok |->
            (o_out_data.consumed >= 7'd2) && (o_out_data.consumed <= 7'd64))
        else $error("consumed count out of range on a good result");

    // a pending result is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before transfer");

    // a pending result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

endmodule

bind time_text_parser ttp_checker u_ttp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
